[rtl/core/prrm_pkg.sv]
// Shared types, constants and helper functions for the PCM ring resampler mixer.
// Used by prrm_channel and pcm_ring_resampler_mixer; depends on nothing else.
package prrm_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;

    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH = 3;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int PHASE_WIDTH    = 12;
    localparam int GAIN_WIDTH     = 11;
    localparam int VOLUME_WIDTH   = 8;
    localparam int GAIN_VOL_WIDTH = GAIN_WIDTH + VOLUME_WIDTH;
    localparam int MIX_WIDTH      = 32;
    localparam int RATE_WIDTH     = 16;
    localparam int BYTE_WIDTH     = 8;
    localparam int WINDOW_BYTES   = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam logic [7:0]  DAC_CTL_RESET    = 8'hff;
    localparam logic [7:0]  VOLUME_RESET     = 8'd128;
    localparam logic [15:0] RATE_STEP_RESET  = 16'd4096;

    typedef enum logic [2:0] {
        CFG_PLAYBACK_ENABLE = 3'd0,
        CFG_DATA_FORMAT     = 3'd1,
        CFG_LEFT_DAC        = 3'd2,
        CFG_RIGHT_DAC       = 3'd3,
        CFG_MASTER_VOLUME   = 3'd4,
        CFG_RATE_STEP       = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_U8   = 2'd0,
        KIND_LE16 = 2'd1,
        KIND_BE16 = 2'd2,
        KIND_NONE = 2'd3
    } sample_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic diff_en;
        logic scale_en;
        logic sum_en;
    } chan_ctl_t;

    localparam logic [GAIN_WIDTH-1:0] GAIN_TABLE [64] = '{
        11'd1024, 11'd861, 11'd724, 11'd609, 11'd513, 11'd431, 11'd363, 11'd305,
        11'd257,  11'd216, 11'd182, 11'd153, 11'd128, 11'd108, 11'd91,  11'd76,
        11'd64,   11'd54,  11'd45,  11'd38,  11'd32,  11'd27,  11'd22,  11'd19,
        11'd16,   11'd13,  11'd11,  11'd9,   11'd8,   11'd6,   11'd5,   11'd4,
        11'd4,    11'd3,   11'd2,   11'd2,   11'd2,   11'd1,   11'd1,   11'd1,
        11'd1,    11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
        11'd0,    11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
        11'd0,    11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0
    };

    function automatic logic [GAIN_WIDTH-1:0] dac_gain(input logic [7:0] ctl);
        if (ctl[7])
        begin
            return '0;
        end
        return GAIN_TABLE[ctl[5:0]];
    endfunction

    function automatic sample_kind_t decode_kind(input logic [3:0] fmt);
        sample_kind_t kind;
        case (fmt[3:1])
            3'd0:    kind = KIND_U8;
            3'd2:    kind = KIND_LE16;
            3'd6:    kind = KIND_BE16;
            default: kind = KIND_NONE;
        endcase
        return kind;
    endfunction

    // Builds a 16-bit sample from the byte at its offset and, if wide, the next.
    function automatic logic signed [SAMPLE_WIDTH-1:0] make_sample(
        input sample_kind_t kind,
        input logic [7:0]   first,
        input logic [7:0]   second
    );
        logic signed [SAMPLE_WIDTH-1:0] value;
        case (kind)
            KIND_U8:   value = {~first[7], first[6:0], 8'h00};
            KIND_LE16: value = {second, first};
            KIND_BE16: value = {first, second};
            default:   value = '0;
        endcase
        return value;
    endfunction

endpackage

[rtl/core/pcm_ring_resampler_mixer.sv]
// Top level of the PCM ring resampler mixer: byte ring buffer, control and output.
// Depends on prrm_pkg and prrm_channel.
//
// A write item stores one byte in the ring buffer; a frame item reads eight bytes
// from the read position on through the two read ports of the buffer memory,
// captured in steps RD1 to RD4, then runs three arithmetic stages per channel
// (MUL1, MUL2, SUM). A frame that is not played (disabled, unsupported format or
// less than one frame buffered) goes straight to the output step like a write.
// One item is in work at a time; its result is held in the output register, and
// the next item is accepted while that result waits. The buffer is not cleared
// after reset.
module pcm_ring_resampler_mixer #(
    parameter int BUFFER_BYTES = prrm_pkg::BUFFER_BYTES_DEF,
    localparam int AW       = $clog2(BUFFER_BYTES),
    localparam int CW       = $clog2(BUFFER_BYTES + 1),
    localparam int OUT_BITS = 2 * prrm_pkg::MIX_WIDTH + CW + 1,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [prrm_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [prrm_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // data_byte[7:0], mix_left[39:8], mix_right[71:40]
    input  logic [71:0]                           s_tdata,
    // op
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_left, out_right, buffered_bytes, overflow, zero fill
    output logic [OUT_W-1:0]                      m_tdata
);

    localparam int SW = AW + 1;
    localparam logic [SW-1:0] BUF_SW = SW'(BUFFER_BYTES);
    localparam logic [CW-1:0] BUF_CW = CW'(BUFFER_BYTES);
    localparam int MW = prrm_pkg::MIX_WIDTH;
    localparam int SMW = prrm_pkg::SAMPLE_WIDTH;

    function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] sum);
        if (sum >= BUF_SW)
        begin
            return AW'(sum - BUF_SW);
        end
        return AW'(sum);
    endfunction

    // Configuration registers
    logic                            enable_reg;
    logic [3:0]                      format_reg;
    logic [7:0]                      left_dac_reg;
    logic [7:0]                      right_dac_reg;
    logic [7:0]                      volume_reg;
    logic [prrm_pkg::RATE_WIDTH-1:0] rate_step_reg;

    // Ring buffer state
    logic [7:0]                      mem [BUFFER_BYTES];
    logic [AW-1:0]                   read_pos_reg;
    logic [CW-1:0]                   fill_count_reg;
    logic [prrm_pkg::PHASE_WIDTH-1:0] phase_reg;

    prrm_pkg::state_t                state_reg;
    prrm_pkg::state_t                state_next;

    logic                            s_fire;
    logic                            in_op;
    logic [7:0]                      in_byte;
    logic signed [MW-1:0]            in_left;
    logic signed [MW-1:0]            in_right;

    logic signed [MW-1:0]            mix_left_reg;
    logic signed [MW-1:0]            mix_right_reg;
    logic                            ovf_reg;
    logic                            played_reg;

    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   ra0;
    logic [AW-1:0]                   ra1;
    logic [2:0]                      rd_off;
    logic [7:0]                      rd0_reg;
    logic [7:0]                      rd1_reg;
    logic [63:0]                     win_reg;

    prrm_pkg::sample_kind_t          kind;
    logic                            wide;
    logic                            stereo;
    logic [1:0]                      frame_shift;
    logic [CW-1:0]                   frame_bytes;
    logic                            frame_ok;

    logic [prrm_pkg::GAIN_VOL_WIDTH-1:0] gv_left_reg;
    logic [prrm_pkg::GAIN_VOL_WIDTH-1:0] gv_right_reg;

    logic signed [SMW-1:0]           l1;
    logic signed [SMW-1:0]           l2;
    logic signed [SMW-1:0]           r1;
    logic signed [SMW-1:0]           r2;
    logic [7:0]                      b [prrm_pkg::WINDOW_BYTES];

    prrm_pkg::chan_ctl_t             chan_ctl;
    logic signed [MW-1:0]            chan_left;
    logic signed [MW-1:0]            chan_right;

    logic [16:0]                     pos;
    logic [4:0]                      used;
    logic [CW-1:0]                   avail;
    logic [4:0]                      used_c;
    logic [6:0]                      cons_bytes;

    logic                            load_out;
    logic                            out_valid_reg;
    logic signed [MW-1:0]            out_left_reg;
    logic signed [MW-1:0]            out_right_reg;
    logic [CW-1:0]                   out_fill_reg;
    logic                            out_ovf_reg;

    assign in_op    = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign in_left  = s_tdata[39:8];
    assign in_right = s_tdata[71:40];
    assign s_fire   = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            format_reg    <= '0;
            left_dac_reg  <= prrm_pkg::DAC_CTL_RESET;
            right_dac_reg <= prrm_pkg::DAC_CTL_RESET;
            volume_reg    <= prrm_pkg::VOLUME_RESET;
            rate_step_reg <= prrm_pkg::RATE_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (prrm_pkg::cfg_index_t'(cfg_addr))
                prrm_pkg::CFG_PLAYBACK_ENABLE: enable_reg    <= cfg_wdata[0];
                prrm_pkg::CFG_DATA_FORMAT:     format_reg    <= cfg_wdata[3:0];
                prrm_pkg::CFG_LEFT_DAC:        left_dac_reg  <= cfg_wdata[7:0];
                prrm_pkg::CFG_RIGHT_DAC:       right_dac_reg <= cfg_wdata[7:0];
                prrm_pkg::CFG_MASTER_VOLUME:   volume_reg    <= cfg_wdata[7:0];
                prrm_pkg::CFG_RATE_STEP:       rate_step_reg <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    // Format decode
    assign kind        = prrm_pkg::decode_kind(format_reg);
    assign wide        = (kind != prrm_pkg::KIND_U8);
    assign stereo      = format_reg[0];
    assign frame_shift = 2'(wide) + 2'(stereo);
    assign frame_bytes = CW'(1) << frame_shift;
    assign frame_ok    = enable_reg && (kind != prrm_pkg::KIND_NONE)
                         && (fill_count_reg >= frame_bytes);

    // Buffer addressing
    assign wr_addr = wrap_addr(SW'(read_pos_reg) + SW'(fill_count_reg));
    assign ra0     = wrap_addr(SW'(read_pos_reg) + SW'(rd_off));
    assign ra1     = wrap_addr(SW'(read_pos_reg) + SW'(rd_off) + SW'(1));

    always_ff @(posedge clk)
    begin
        if (s_fire && (in_op == prrm_pkg::OP_WRITE) && (fill_count_reg != BUF_CW))
        begin
            mem[wr_addr] <= in_byte;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // Control sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prrm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_off     = 3'd0;
        chan_ctl   = '0;
        load_out   = 1'b0;
        case (state_reg)
            prrm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_off   = 3'd0;
                if (s_tvalid)
                begin
                    if ((in_op == prrm_pkg::OP_FRAME) && frame_ok)
                    begin
                        state_next = prrm_pkg::ST_RD1;
                    end
                    else
                    begin
                        state_next = prrm_pkg::ST_DONE;
                    end
                end
            end
            prrm_pkg::ST_RD1:
            begin
                rd_off     = 3'd2;
                state_next = prrm_pkg::ST_RD2;
            end
            prrm_pkg::ST_RD2:
            begin
                rd_off     = 3'd4;
                state_next = prrm_pkg::ST_RD3;
            end
            prrm_pkg::ST_RD3:
            begin
                rd_off     = 3'd6;
                state_next = prrm_pkg::ST_RD4;
            end
            prrm_pkg::ST_RD4:
            begin
                state_next = prrm_pkg::ST_MUL1;
            end
            prrm_pkg::ST_MUL1:
            begin
                chan_ctl.diff_en = 1'b1;
                state_next       = prrm_pkg::ST_MUL2;
            end
            prrm_pkg::ST_MUL2:
            begin
                chan_ctl.scale_en = 1'b1;
                state_next        = prrm_pkg::ST_SUM;
            end
            prrm_pkg::ST_SUM:
            begin
                chan_ctl.sum_en = 1'b1;
                state_next      = prrm_pkg::ST_DONE;
            end
            prrm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = prrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Item registers and read window
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            mix_left_reg  <= in_left;
            mix_right_reg <= in_right;
            ovf_reg       <= (in_op == prrm_pkg::OP_WRITE) && (fill_count_reg == BUF_CW);
            played_reg    <= (in_op == prrm_pkg::OP_FRAME) && frame_ok;
        end
        case (state_reg)
            prrm_pkg::ST_RD1:
            begin
                win_reg[15:0] <= {rd1_reg, rd0_reg};
                gv_left_reg   <= prrm_pkg::dac_gain(left_dac_reg) * volume_reg;
                gv_right_reg  <= prrm_pkg::dac_gain(right_dac_reg) * volume_reg;
            end
            prrm_pkg::ST_RD2: win_reg[31:16] <= {rd1_reg, rd0_reg};
            prrm_pkg::ST_RD3: win_reg[47:32] <= {rd1_reg, rd0_reg};
            prrm_pkg::ST_RD4: win_reg[63:48] <= {rd1_reg, rd0_reg};
            default:          ;
        endcase
    end

    // Sample selection from the eight-byte window
    always_comb
    begin
        for (int i = 0; i < prrm_pkg::WINDOW_BYTES; i++)
        begin
            b[i] = win_reg[8*i +: 8];
        end
        case ({wide, stereo})
            2'b00:
            begin
                l1 = prrm_pkg::make_sample(kind, b[0], b[1]);
                l2 = prrm_pkg::make_sample(kind, b[1], b[2]);
                r1 = l1;
                r2 = l2;
            end
            2'b01:
            begin
                l1 = prrm_pkg::make_sample(kind, b[0], b[1]);
                l2 = prrm_pkg::make_sample(kind, b[2], b[3]);
                r1 = prrm_pkg::make_sample(kind, b[1], b[2]);
                r2 = prrm_pkg::make_sample(kind, b[3], b[4]);
            end
            2'b10:
            begin
                l1 = prrm_pkg::make_sample(kind, b[0], b[1]);
                l2 = prrm_pkg::make_sample(kind, b[2], b[3]);
                r1 = l1;
                r2 = l2;
            end
            default:
            begin
                l1 = prrm_pkg::make_sample(kind, b[0], b[1]);
                l2 = prrm_pkg::make_sample(kind, b[4], b[5]);
                r1 = prrm_pkg::make_sample(kind, b[2], b[3]);
                r2 = prrm_pkg::make_sample(kind, b[6], b[7]);
            end
        endcase
    end

    prrm_channel u_left (
        .clk      (clk),
        .ctl      (chan_ctl),
        .s1       (l1),
        .s2       (l2),
        .phase    (phase_reg),
        .gain_vol (gv_left_reg),
        .mix      (mix_left_reg),
        .result   (chan_left)
    );

    prrm_channel u_right (
        .clk      (clk),
        .ctl      (chan_ctl),
        .s1       (r1),
        .s2       (r2),
        .phase    (phase_reg),
        .gain_vol (gv_right_reg),
        .mix      (mix_right_reg),
        .result   (chan_right)
    );

    // Frame consumption
    assign pos        = 17'(phase_reg) + 17'(rate_step_reg);
    assign used       = pos[16:12];
    assign avail      = fill_count_reg >> frame_shift;
    assign used_c     = (avail < CW'(used)) ? avail[4:0] : used;
    assign cons_bytes = 7'(used_c) << frame_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pos_reg   <= '0;
            fill_count_reg <= '0;
            phase_reg      <= '0;
        end
        else if (s_fire && (in_op == prrm_pkg::OP_WRITE))
        begin
            if (fill_count_reg != BUF_CW)
            begin
                fill_count_reg <= fill_count_reg + CW'(1);
            end
        end
        else if (state_reg == prrm_pkg::ST_SUM)
        begin
            read_pos_reg   <= wrap_addr(SW'(read_pos_reg) + SW'(cons_bytes));
            fill_count_reg <= fill_count_reg - CW'(cons_bytes);
            phase_reg      <= pos[prrm_pkg::PHASE_WIDTH-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_left_reg  <= played_reg ? chan_left : mix_left_reg;
            out_right_reg <= played_reg ? chan_right : mix_right_reg;
            out_fill_reg  <= fill_count_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_ovf_reg, out_fill_reg, out_right_reg, out_left_reg});

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= BUF_CW)
        else $error("fill count exceeds buffer size");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(read_pos_reg) < BUF_SW)
        else $error("read position outside buffer");

    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (in_op == prrm_pkg::OP_WRITE) && (fill_count_reg != BUF_CW))
        |=> (fill_count_reg == $past(fill_count_reg) + CW'(1)))
        else $error("accepted write did not grow the fill count");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_ovf_reg) |-> (out_fill_reg == BUF_CW))
        else $error("overflow flagged while buffer not full");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != prrm_pkg::ST_SUM) |=> $stable(phase_reg))
        else $error("phase changed outside the consume step");

endmodule

[rtl/core/prrm_channel.sv]
// One channel of the resampler arithmetic: interpolation, gain and mix add.
// Depends on prrm_pkg; instantiated twice by pcm_ring_resampler_mixer.
module prrm_channel (
    input  logic                                      clk,
    input  prrm_pkg::chan_ctl_t                       ctl,
    input  logic signed [prrm_pkg::SAMPLE_WIDTH-1:0]  s1,
    input  logic signed [prrm_pkg::SAMPLE_WIDTH-1:0]  s2,
    input  logic [prrm_pkg::PHASE_WIDTH-1:0]          phase,
    input  logic [prrm_pkg::GAIN_VOL_WIDTH-1:0]       gain_vol,
    input  logic signed [prrm_pkg::MIX_WIDTH-1:0]     mix,
    output logic signed [prrm_pkg::MIX_WIDTH-1:0]     result
);

    localparam int DW = prrm_pkg::SAMPLE_WIDTH + 1;
    localparam int P1W = DW + prrm_pkg::PHASE_WIDTH + 1;
    localparam int P2W = DW + prrm_pkg::GAIN_VOL_WIDTH + 1;

    logic signed [DW-1:0]                    diff;
    logic signed [P1W-1:0]                   diff_w;
    logic signed [P1W-1:0]                   phase_w;
    logic signed [P1W-1:0]                   prod1_reg;
    logic signed [P1W-1:0]                   prod1_shift;
    logic signed [DW-1:0]                    interp;
    logic signed [P2W-1:0]                   interp_w;
    logic signed [P2W-1:0]                   gv_w;
    logic signed [P2W-1:0]                   prod2_reg;
    logic signed [P2W-1:0]                   prod2_shift;
    logic signed [prrm_pkg::MIX_WIDTH-1:0]   result_reg;

    assign diff        = DW'(s2) - DW'(s1);
    assign diff_w      = P1W'(diff);
    assign phase_w     = $signed(P1W'(phase));
    assign prod1_shift = prod1_reg >>> prrm_pkg::PHASE_WIDTH;
    assign interp      = DW'(s1) + DW'(prod1_shift);
    assign interp_w    = P2W'(interp);
    assign gv_w        = $signed(P2W'(gain_vol));
    assign prod2_shift = prod2_reg >>> 15;

    always_ff @(posedge clk)
    begin
        if (ctl.diff_en)
        begin
            prod1_reg <= diff_w * phase_w;
        end
        if (ctl.scale_en)
        begin
            prod2_reg <= interp_w * gv_w;
        end
        if (ctl.sum_en)
        begin
            result_reg <= mix + prrm_pkg::MIX_WIDTH'(prod2_shift);
        end
    end

    assign result = result_reg;

endmodule

[test/pcm_ring_resampler_mixer_test.sv]
// Self-checking testbench for pcm_ring_resampler_mixer: drives byte and frame items
// with random gaps and checks every result against a predictor of the ring, the
// interpolator and the mixer. Depends on prrm_pkg and the RTL of the block.
module pcm_ring_resampler_mixer_test;

    localparam int RING_BYTES  = 4096;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic [31:0] mix_left;
        logic [31:0] mix_right;
    } codec_item_t;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
        logic [12:0] level;
        logic        overflow;
    } mix_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;

    // Ring contents and pointers as the block should hold them.
    logic [7:0]  ring_mem [RING_BYTES];
    logic [11:0] rd_ptr = '0;
    logic [12:0] level  = '0;
    logic [11:0] frac   = '0;
    int          wr_total = 0;

    logic        play_en  = 1'b0;
    logic [3:0]  fmt_reg  = 4'd0;
    logic [7:0]  dac_left = prrm_pkg::DAC_CTL_RESET;
    logic [7:0]  dac_right = prrm_pkg::DAC_CTL_RESET;
    logic [7:0]  vol_reg  = prrm_pkg::VOLUME_RESET;
    logic [15:0] step_reg = prrm_pkg::RATE_STEP_RESET;

    int          gains [64];

    codec_item_t codec_items_q [$];
    mix_result_t mixed_q [$];
    codec_item_t offered;
    int          tx_gap     = 0;
    int          rx_gap     = 0;
    logic        idle_en    = 1'b1;
    logic        rx_hold    = 1'b0;
    logic        random_on  = 1'b0;
    int          fail_count = 0;

    pcm_ring_resampler_mixer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] rand_mix();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int stored_sample(prrm_pkg::sample_kind_t kind, int off);
        logic [11:0] addr;
        logic [7:0]  first;
        logic [7:0]  second;
        addr   = rd_ptr + off[11:0];
        first  = ring_mem[addr];
        addr   = addr + 12'd1;
        second = ring_mem[addr];
        if (kind == prrm_pkg::KIND_U8)
        begin
            return (int'(first) - 128) * 256;
        end
        if (kind == prrm_pkg::KIND_LE16)
        begin
            return int'($signed({second, first}));
        end
        return int'($signed({first, second}));
    endfunction

    function automatic logic [31:0] scale_and_add(logic [31:0] mix, int off, int frame_len,
                                                  prrm_pkg::sample_kind_t kind,
                                                  logic [7:0] dac);
        longint s1;
        longint s2;
        longint interp;
        longint scaled;
        longint gain;
        s1     = stored_sample(kind, off);
        s2     = stored_sample(kind, off + frame_len);
        gain   = dac[7] ? 0 : gains[dac[5:0]];
        interp = s1 + (((s2 - s1) * longint'(frac)) >>> 12);
        scaled = (interp * gain * longint'(vol_reg)) >>> 15;
        return mix + scaled[31:0];
    endfunction

    // True when a frame item would now be played and would read ring bytes that
    // were never written since reset.
    function automatic logic frame_reads_unwritten();
        prrm_pkg::sample_kind_t kind;
        int                     width;
        int                     frame_len;
        logic [11:0]            addr;
        logic                   hit;
        hit  = 1'b0;
        kind = prrm_pkg::decode_kind(fmt_reg);
        if (play_en && (kind != prrm_pkg::KIND_NONE))
        begin
            width     = (kind == prrm_pkg::KIND_U8) ? 1 : 2;
            frame_len = fmt_reg[0] ? 2 * width : width;
            if (int'(level) >= frame_len)
            begin
                for (int k = 0; k < 2 * frame_len; k++)
                begin
                    addr = rd_ptr + 12'(k);
                    if ((wr_total < RING_BYTES) && (int'(addr) >= wr_total))
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    function automatic mix_result_t resample_and_mix(codec_item_t it);
        mix_result_t            r;
        prrm_pkg::sample_kind_t kind;
        int                     width;
        int                     frame_len;
        int                     avail;
        int                     used;
        logic [16:0]            pos;
        r.left     = it.mix_left;
        r.right    = it.mix_right;
        r.overflow = 1'b0;
        if (it.op == prrm_pkg::OP_WRITE)
        begin
            if (level >= RING_BYTES)
            begin
                r.overflow = 1'b1;
            end
            else
            begin
                ring_mem[rd_ptr + level[11:0]] = it.data;
                level = level + 13'd1;
                if (wr_total < RING_BYTES)
                begin
                    wr_total = wr_total + 1;
                end
            end
        end
        else if (play_en)
        begin
            case (fmt_reg[3:1])
                3'd0:    kind = prrm_pkg::KIND_U8;
                3'd2:    kind = prrm_pkg::KIND_LE16;
                3'd6:    kind = prrm_pkg::KIND_BE16;
                default: kind = prrm_pkg::KIND_NONE;
            endcase
            if (kind != prrm_pkg::KIND_NONE)
            begin
                width     = (kind == prrm_pkg::KIND_U8) ? 1 : 2;
                frame_len = fmt_reg[0] ? 2 * width : width;
                avail     = int'(level) / frame_len;
                if (avail != 0)
                begin
                    r.left  = scale_and_add(it.mix_left, 0, frame_len, kind, dac_left);
                    r.right = scale_and_add(it.mix_right, fmt_reg[0] ? width : 0, frame_len,
                                            kind, dac_right);
                    pos  = frac + step_reg;
                    used = int'(pos[16:12]);
                    if (used > avail)
                    begin
                        used = avail;
                    end
                    level  = level - 13'(used * frame_len);
                    rd_ptr = rd_ptr + 12'(used * frame_len);
                    frac   = pos[11:0];
                end
            end
        end
        r.level = level;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (fail_count < 100)
        begin
            $display("mismatch: %s got %h expected %h", what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (codec_items_q.size() > 0)
                begin
                    offered = codec_items_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.op;
                    s_tdata  <= {offered.mix_right, offered.mix_left, offered.data};
                    tx_gap = idle_en ? pick_gap() : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        mix_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (mixed_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_tdata[31:0], '0);
                end
                else
                begin
                    want = mixed_q.pop_front();
                    if (m_tdata[31:0] !== want.left)
                    begin
                        report_mismatch("out_left", m_tdata[31:0], want.left);
                    end
                    if (m_tdata[63:32] !== want.right)
                    begin
                        report_mismatch("out_right", m_tdata[63:32], want.right);
                    end
                    if (m_tdata[76:64] !== want.level)
                    begin
                        report_mismatch("buffered_bytes", 32'(m_tdata[76:64]), 32'(want.level));
                    end
                    if (m_tdata[77] !== want.overflow)
                    begin
                        report_mismatch("overflow", 32'(m_tdata[77]), 32'(want.overflow));
                    end
                end
            end
            if (rx_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (idle_en && $urandom_range(0, 3) == 0)
                begin
                    rx_gap = pick_gap();
                end
                m_tready <= (rx_gap == 0);
            end
        end
    end

    // The receiver stops for a long stretch while the sender keeps offering items.
    initial
    begin
        while (!(random_on && codec_items_q.size() > 40))
        begin
            @(negedge clk);
        end
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(prrm_pkg::cfg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            prrm_pkg::CFG_PLAYBACK_ENABLE: play_en   = val[0];
            prrm_pkg::CFG_DATA_FORMAT:     fmt_reg   = val[3:0];
            prrm_pkg::CFG_LEFT_DAC:        dac_left  = val[7:0];
            prrm_pkg::CFG_RIGHT_DAC:       dac_right = val[7:0];
            prrm_pkg::CFG_MASTER_VOLUME:   vol_reg   = val[7:0];
            prrm_pkg::CFG_RATE_STEP:       step_reg  = val;
            default:                       ;
        endcase
    endtask

    task automatic set_regs(logic en, logic [3:0] fmt, logic [7:0] left, logic [7:0] right,
                            logic [7:0] vol, logic [15:0] step);
        write_reg(prrm_pkg::CFG_PLAYBACK_ENABLE, {15'd0, en});
        write_reg(prrm_pkg::CFG_DATA_FORMAT, {12'd0, fmt});
        write_reg(prrm_pkg::CFG_LEFT_DAC, {8'd0, left});
        write_reg(prrm_pkg::CFG_RIGHT_DAC, {8'd0, right});
        write_reg(prrm_pkg::CFG_MASTER_VOLUME, {8'd0, vol});
        write_reg(prrm_pkg::CFG_RATE_STEP, step);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Items are predicted as they are queued; the block takes them in the same order.
    task automatic push_item(logic op, logic [7:0] data, logic [31:0] ml, logic [31:0] mr);
        codec_item_t it;
        it.op        = op;
        it.data      = data;
        it.mix_left  = ml;
        it.mix_right = mr;
        // A frame that would interpolate from never-written ring bytes is sent as a write.
        if ((it.op == prrm_pkg::OP_FRAME) && frame_reads_unwritten())
        begin
            it.op = prrm_pkg::OP_WRITE;
        end
        mixed_q.push_back(resample_and_mix(it));
        codec_items_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (codec_items_q.size() != 0 || s_tvalid || mixed_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_dac();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80 | 8'($urandom_range(0, 127));
            3:       return 8'($urandom_range(0, 63));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'd4096;
            3:       return 16'($urandom_range(1, 4095));
            4:       return 16'($urandom_range(4097, 12288));
            5:       return 16'($urandom_range(0, 65535));
            6:       return 16'd4095;
            default: return 16'($urandom_range(2048, 6144));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [3:0] fmt;
        logic [7:0] vol;
        int         wr_pct;
        case ($urandom_range(0, 7))
            0:       fmt = 4'($urandom_range(0, 15));
            1:       fmt = 4'd0;
            2:       fmt = 4'd1;
            3:       fmt = 4'd4;
            4:       fmt = 4'd5;
            5:       fmt = 4'd12;
            default: fmt = 4'd13;
        endcase
        case ($urandom_range(0, 4))
            0:       vol = 8'd0;
            1:       vol = 8'd255;
            default: vol = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       wr_pct = 90;
            1:       wr_pct = 15;
            default: wr_pct = $urandom_range(35, 70);
        endcase
        set_regs($urandom_range(0, 9) != 0, fmt, rand_dac(), rand_dac(), vol, rand_step());
        idle_en = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++)
        begin
            push_item(($urandom_range(0, 99) < wr_pct) ? prrm_pkg::OP_WRITE : prrm_pkg::OP_FRAME,
                      8'($urandom), rand_mix(), rand_mix());
        end
        wait_drained();
    endtask

    initial
    begin
        for (int a = 0; a < 64; a++)
        begin
            gains[a] = $rtoi(1024.0 * (10.0 ** (-0.075 * a)));
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Disabled playback with an empty ring, then a few hundred bytes stored.
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h8000_0000, 32'h7fff_ffff);
        push_item(prrm_pkg::OP_WRITE, 8'h00, 32'h7fff_ffff, 32'h8000_0000);
        push_item(prrm_pkg::OP_WRITE, 8'hff, 32'h0000_0000, 32'hffff_ffff);
        push_item(prrm_pkg::OP_WRITE, 8'h80, rand_mix(), rand_mix());
        push_item(prrm_pkg::OP_WRITE, 8'h7f, rand_mix(), rand_mix());
        for (int i = 4; i < 300; i++)
        begin
            push_item(prrm_pkg::OP_WRITE, 8'($urandom), rand_mix(), rand_mix());
        end
        push_item(prrm_pkg::OP_WRITE, 8'hff, 32'h8000_0000, 32'h7fff_ffff);
        push_item(prrm_pkg::OP_WRITE, 8'h00, 32'hffff_ffff, 32'h0000_0000);
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h1234_5678, 32'h8765_4321);
        wait_drained();

        set_regs(1'b1, 4'd0, 8'h00, 8'h80, 8'd255, 16'd2048);
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h7fff_ffff, 32'h8000_0000);
        push_item(prrm_pkg::OP_FRAME, 8'hff, 32'h8000_0000, 32'h7fff_ffff);
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h0000_0000, 32'hffff_ffff);
        wait_drained();

        set_regs(1'b1, 4'd5, 8'h40, 8'h3f, 8'd1, 16'hffff);
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h7fff_ffff, 32'h7fff_ffff);
        push_item(prrm_pkg::OP_FRAME, 8'h00, 32'h8000_0000, 32'h8000_0000);
        wait_drained();

        set_regs(1'b1, 4'd12, 8'h07, 8'h1f, 8'd128, 16'd0);
        push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        wait_drained();

        set_regs(1'b1, 4'd2, 8'h00, 8'h00, 8'd255, 16'd4096);
        push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        wait_drained();

        // Stereo drain at the largest step, so that frames meet a ring holding less
        // than one frame.
        set_regs(1'b1, 4'd13, 8'h00, 8'h00, 8'd255, 16'hffff);
        for (int i = 0; i < 70; i++)
        begin
            push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        end
        push_item(prrm_pkg::OP_WRITE, 8'h80, rand_mix(), rand_mix());
        push_item(prrm_pkg::OP_WRITE, 8'h01, rand_mix(), rand_mix());
        push_item(prrm_pkg::OP_WRITE, 8'hfe, rand_mix(), rand_mix());
        push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        wait_drained();

        set_regs(1'b0, 4'd13, 8'h00, 8'h00, 8'd255, 16'd4096);
        push_item(prrm_pkg::OP_FRAME, 8'h00, rand_mix(), rand_mix());
        wait_drained();

        random_on = 1'b1;
        for (int p = 0; p < 11; p++)
        begin
            random_phase(100);
        end

        repeat (20) @(posedge clk);
        if (mixed_q.size() != 0)
        begin
            report_mismatch("results never delivered", 32'(mixed_q.size()), '0);
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
